### hdl/tts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_pkg
// Shared constants, codes and types of the timed task slot scheduler.
// ----------------------------------------------------------------------------
package tts_pkg;

    localparam int SLOTS = 16;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [1:0] {
        OP_ADD        = 2'd0,
        OP_CANCEL     = 2'd1,
        OP_CANCEL_ALL = 2'd2,
        OP_PERIODIC   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic             capture;
        logic             step;
        logic [IDX_W-1:0] idx;
        logic             finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hold;
        logic out_free;
    } stat_t;

    // exponential delay: larger delays count down only on some phases
    function automatic logic dec_allowed(input logic [7:0] d, input logic [3:0] ph);
        logic r;
        if ((d & 8'h80) != 8'h00) begin
            r = ((ph & 4'h0f) == 4'h0);
        end else if ((d & 8'hc0) != 8'h00) begin
            r = ((ph & 4'h07) == 4'h0);
        end else if ((d & 8'he0) != 8'h00) begin
            r = ((ph & 4'h03) == 4'h0);
        end else if ((d & 8'hf0) != 8'h00) begin
            r = ((ph & 4'h01) == 4'h0);
        end else begin
            r = 1'b1;
        end
        return r;
    endfunction

endpackage

### hdl/timed_task_slot_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_task_slot_scheduler
// Task slot table with add, cancel, cancel all and periodic dispatch/tick.
//
//   port group  dir  tdata (low bit up)              tuser       tlast
//   s_*         in   task_id, delay, param           op          -
//   m_*         out  ok, out_task, out_param,        kind        last
//                    any_pending (6 pad bits)
//
// An accepted beat scans the table one slot per cycle while no dispatch is
// held by the output, then commits and loads the status beat once the output
// register is free; cancel all skips the scan. Ready is low from accept to
// commit. The scan index counter on the one slot read port sets the pace.
// Dispatch beats are emitted during the scan; a stalled m_tready holds the
// scan on the slot being dispatched. Reset clears the table and tick phase.
// ----------------------------------------------------------------------------
module timed_task_slot_scheduler import tts_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // task_id, delay, param
    input  logic [1:0]  s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // ok, out_task, out_param, any_pending
    output logic        m_tuser,   // kind
    output logic        m_tlast
);

    cmd_t       cmd;
    stat_t      stat;
    logic       ok, anyp;
    logic [7:0] otask, oparam;

    tts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_op     (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    tts_datapath u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .in_op           (s_tuser),
        .in_task_id      (s_tdata[7:0]),
        .in_delay        (s_tdata[15:8]),
        .in_param        (s_tdata[23:16]),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .out_kind        (m_tuser),
        .out_ok          (ok),
        .out_task        (otask),
        .out_param       (oparam),
        .out_any_pending (anyp),
        .out_last        (m_tlast)
    );

    assign m_tdata = {6'd0, anyp, oparam, otask, ok};

endmodule

### hdl/tts_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_ctrl
// Sequencer: accepts a beat, walks the slot index once (not for cancel all), then commits.
// ----------------------------------------------------------------------------
module tts_ctrl import tts_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [1:0] s_op,
    input  stat_t      stat,
    output cmd_t       cmd
);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        cmd.capture = 1'b0;
        cmd.step    = 1'b0;
        cmd.finish  = 1'b0;
        cmd.idx     = idx_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.capture = 1'b1;
                    idx_next    = '0;
                    if (op_t'(s_op) == OP_CANCEL_ALL) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                cmd.step = 1'b1;
                if (!stat.hold) begin
                    if (idx_reg == IDX_W'(SLOTS - 1)) begin
                        state_next = ST_DONE;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            ST_DONE: begin
                // status beat needs the output register
                if (stat.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

### hdl/tts_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_datapath
// Slot table, scan bookkeeping, tick phase and the output register.
// ----------------------------------------------------------------------------
module tts_datapath import tts_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  logic [1:0]  in_op,
    input  logic [7:0]  in_task_id,
    input  logic [7:0]  in_delay,
    input  logic [7:0]  in_param,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic        out_kind,
    output logic        out_ok,
    output logic [7:0]  out_task,
    output logic [7:0]  out_param,
    output logic        out_any_pending,
    output logic        out_last
);

    logic [SLOTS-1:0] used_reg;
    logic [7:0]       task_reg  [SLOTS];
    logic [7:0]       param_reg [SLOTS];
    logic [7:0]       delay_reg [SLOTS];
    logic [3:0]       phase_reg;

    op_t              op_reg;
    logic [7:0]       id_reg, dly_reg, par_reg;
    logic             match_found_reg, tgt_found_reg, pend_reg;
    logic [IDX_W-1:0] match_idx_reg, tgt_idx_reg;

    logic             valid_reg;
    logic             kind_reg, ok_reg, anyp_reg, last_reg;
    logic [7:0]       otask_reg, oparam_reg;

    logic             cur_used, id_hit, dispatch, out_free, id_nz;
    logic [7:0]       cur_task, cur_param, cur_delay;
    logic [3:0]       phase_new;

    assign cur_used  = used_reg[cmd.idx];
    assign cur_task  = task_reg[cmd.idx];
    assign cur_param = param_reg[cmd.idx];
    assign cur_delay = delay_reg[cmd.idx];
    assign phase_new = phase_reg + 4'd1;
    assign id_nz     = (id_reg != 8'd0);
    assign id_hit    = cur_used && (cur_task == id_reg) && id_nz;
    assign out_free  = !valid_reg || m_tready;
    assign dispatch  = cmd.step && (op_reg == OP_PERIODIC) && cur_used &&
                       (cur_delay == 8'd0);

    assign stat.out_free = out_free;
    assign stat.hold     = dispatch && !out_free;

    // slot table
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg  <= '0;
            phase_reg <= 4'd0;
        end else begin
            if (cmd.step && op_reg == OP_PERIODIC && cur_used) begin
                if (cur_delay == 8'd0) begin
                    if (out_free) begin
                        used_reg[cmd.idx] <= 1'b0;
                    end
                end else if (dec_allowed(cur_delay, phase_new)) begin
                    delay_reg[cmd.idx] <= cur_delay - 8'd1;
                end
            end
            if (cmd.finish) begin
                case (op_reg)
                    OP_ADD: begin
                        // the target may be the slot just freed
                        if (match_found_reg &&
                            !(tgt_found_reg && tgt_idx_reg == match_idx_reg)) begin
                            used_reg[match_idx_reg] <= 1'b0;
                        end
                        if (tgt_found_reg) begin
                            used_reg[tgt_idx_reg]  <= 1'b1;
                            task_reg[tgt_idx_reg]  <= id_reg;
                            param_reg[tgt_idx_reg] <= par_reg;
                            delay_reg[tgt_idx_reg] <= dly_reg;
                        end
                    end
                    OP_CANCEL: begin
                        if (match_found_reg) begin
                            used_reg[match_idx_reg] <= 1'b0;
                        end
                    end
                    OP_CANCEL_ALL: begin
                        used_reg <= '0;
                    end
                    OP_PERIODIC: begin
                        phase_reg <= phase_new;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // scan bookkeeping
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg          <= op_t'(in_op);
            id_reg          <= in_task_id;
            dly_reg         <= in_delay;
            par_reg         <= in_param;
            match_found_reg <= 1'b0;
            tgt_found_reg   <= 1'b0;
            pend_reg        <= 1'b0;
            match_idx_reg   <= '0;
            tgt_idx_reg     <= '0;
        end else if (cmd.step) begin
            if (id_hit && !match_found_reg) begin
                match_found_reg <= 1'b1;
                match_idx_reg   <= cmd.idx;
            end
            // first free slot, counting the one the add itself cancels
            if (op_reg == OP_ADD && id_nz && !tgt_found_reg &&
                (!cur_used || (id_hit && !match_found_reg))) begin
                tgt_found_reg <= 1'b1;
                tgt_idx_reg   <= cmd.idx;
            end
            if (op_reg == OP_PERIODIC && cur_used) begin
                pend_reg <= 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (dispatch && out_free) begin
            valid_reg <= 1'b1;
        end else if (cmd.finish) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (dispatch && out_free) begin
            kind_reg   <= 1'b1;
            ok_reg     <= 1'b0;
            otask_reg  <= cur_task;
            oparam_reg <= cur_param;
            anyp_reg   <= 1'b0;
            last_reg   <= 1'b0;
        end else if (cmd.finish) begin
            kind_reg   <= 1'b0;
            otask_reg  <= 8'd0;
            oparam_reg <= 8'd0;
            last_reg   <= 1'b1;
            anyp_reg   <= (op_reg == OP_PERIODIC) && pend_reg;
            case (op_reg)
                OP_ADD:    ok_reg <= tgt_found_reg;
                OP_CANCEL: ok_reg <= match_found_reg;
                default:   ok_reg <= 1'b0;
            endcase
        end
    end

    assign m_tvalid        = valid_reg;
    assign out_kind        = kind_reg;
    assign out_ok          = ok_reg;
    assign out_task        = otask_reg;
    assign out_param       = oparam_reg;
    assign out_any_pending = anyp_reg;
    assign out_last        = last_reg;

endmodule

### tb/sv/tb_timed_task_slot_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timed_task_slot_scheduler
// Self-checking bench for the task slot scheduler. A short table of directed
// beats walks the table through empty, full, re-add, cancel and the delay
// classes, then random add/cancel/cancel-all/periodic traffic runs with bursty input,
// a patterned output stall, one long output hold-off and one drain pause.
// Every output beat is checked field by field against a local slot table
// model fed by each accepted input beat, or against a directed row's status.
// ----------------------------------------------------------------------------
module tb_timed_task_slot_scheduler;
    import tts_pkg::*;

    localparam int RAND_ITEMS = 214;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD = 300;
    localparam int DRAIN_CYCLES = 2 * SLOTS + 8;
    localparam int NROWS = 20;

    typedef struct packed {
        logic       kind;
        logic       ok;
        logic [7:0] tid;
        logic [7:0] tpar;
        logic       pend;
        logic       fin;
    } sched_beat_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] id;
        logic [7:0] dly;
        logic [7:0] par;
        logic [4:0] cnt;
        logic       typed;
        logic       t_ok;
        logic       t_pend;
    } dir_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // task_id, delay, param
    logic [1:0]  s_tuser;   // op
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // ok, out_task, out_param, any_pending
    logic        m_tuser;   // kind
    logic        m_tlast;

    // local copy of the slot table
    logic       slot_used  [SLOTS];
    logic [7:0] slot_tid   [SLOTS];
    logic [7:0] slot_tpar  [SLOTS];
    logic [7:0] slot_dly   [SLOTS];
    logic [3:0] tick_ph;

    sched_beat_t owed_beats[$];
    dir_row_t    dir_rows [NROWS];
    int          n_errors = 0;
    int          cycle_cnt = 0;
    int          burst_left = 0;
    bit          hold_req = 0;

    timed_task_slot_scheduler dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic bit drop_id(input logic [7:0] id);
        bit hit;
        hit = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            if (!hit && slot_used[i] && slot_tid[i] == id) begin
                slot_used[i] = 1'b0;
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    // applies one op to the local table and queues the beats it owes
    task automatic run_scheduler_op(input op_t op, input logic [7:0] id,
                                    input logic [7:0] dly, input logic [7:0] par);
        sched_beat_t b;
        bit          busy;
        bit          placed;
        logic [3:0]  mask;
        b = '0;
        b.fin = 1'b1;
        busy = 1'b0;
        placed = 1'b0;
        case (op)
            OP_ADD: begin
                if (id != 8'd0) begin
                    void'(drop_id(id));
                    for (int i = 0; i < SLOTS; i++) begin
                        if (!placed && !slot_used[i]) begin
                            slot_used[i] = 1'b1;
                            slot_tid[i]  = id;
                            slot_tpar[i] = par;
                            slot_dly[i]  = dly;
                            placed = 1'b1;
                        end
                    end
                end
                b.ok = placed;
            end
            OP_CANCEL: begin
                if (id != 8'd0) begin
                    b.ok = drop_id(id);
                end
            end
            OP_CANCEL_ALL: begin
                for (int i = 0; i < SLOTS; i++) begin
                    slot_used[i] = 1'b0;
                end
            end
            default: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_used[i]) begin
                        busy = 1'b1;
                        if (slot_dly[i] == 8'd0) begin
                            slot_used[i] = 1'b0;
                            owed_beats.push_back('{kind: 1'b1, ok: 1'b0, tid: slot_tid[i],
                                                   tpar: slot_tpar[i], pend: 1'b0,
                                                   fin: 1'b0});
                        end
                    end
                end
                tick_ph = tick_ph + 4'd1;
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_used[i] && slot_dly[i] != 8'd0) begin
                        // higher delay classes only count on coarser phases
                        if (slot_dly[i][7])      mask = 4'hf;
                        else if (slot_dly[i][6]) mask = 4'h7;
                        else if (slot_dly[i][5]) mask = 4'h3;
                        else if (slot_dly[i][4]) mask = 4'h1;
                        else                     mask = 4'h0;
                        if ((tick_ph & mask) == 4'h0) begin
                            slot_dly[i] = slot_dly[i] - 8'd1;
                        end
                    end
                end
                b.pend = busy;
            end
        endcase
        owed_beats.push_back(b);
    endtask

    task automatic offer_beat(input op_t op, input logic [7:0] id, input logic [7:0] dly,
                              input logic [7:0] par, input bit typed, input bit t_ok,
                              input bit t_pend);
        int          gap;
        sched_beat_t b;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {par, dly, id};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        run_scheduler_op(op, id, dly, par);
        if (typed) begin
            // status-only row: the obvious answer replaces the model's beat
            b = owed_beats.pop_back();
            b = '0;
            b.ok = t_ok;
            b.pend = t_pend;
            b.fin = 1'b1;
            owed_beats.push_back(b);
        end
    endtask

    task automatic cmp_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            n_errors++;
        end
    endtask

    always @(posedge aclk) begin : out_mon
        sched_beat_t got;
        sched_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind = m_tuser;
            got.ok   = m_tdata[0];
            got.tid  = m_tdata[8:1];
            got.tpar = m_tdata[16:9];
            got.pend = m_tdata[17];
            got.fin  = m_tlast;
            if (owed_beats.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual 0x%0h", $time, got);
                n_errors++;
            end else begin
                want = owed_beats.pop_front();
                cmp_field("kind", int'(want.kind), int'(got.kind));
                cmp_field("ok", int'(want.ok), int'(got.ok));
                cmp_field("out_task", int'(want.tid), int'(got.tid));
                cmp_field("out_param", int'(want.tpar), int'(got.tpar));
                cmp_field("any_pending", int'(want.pend), int'(got.pend));
                cmp_field("last", int'(want.fin), int'(got.fin));
            end
        end
    end

    // output side: stall modes of random length, plus one long hold-off on request
    initial begin : rx_side
        int mode;
        int mode_left;
        int hold_cnt;
        mode = 0;
        mode_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                hold_cnt = 0;
                while (hold_cnt < LONG_HOLD) begin
                    @(posedge aclk);
                    hold_cnt++;
                end
                hold_req = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(10, 60);
                end
                mode_left--;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    initial begin : stim
        dir_row_t   row;
        op_t        op;
        logic [7:0] id;
        logic [7:0] dly;
        int         r;
        for (int i = 0; i < SLOTS; i++) begin
            slot_used[i] = 1'b0;
            slot_tid[i]  = 8'd0;
            slot_tpar[i] = 8'd0;
            slot_dly[i]  = 8'd0;
        end
        tick_ph = 4'd0;
        dir_rows = '{
            '{OP_PERIODIC,   8'h00, 8'h00, 8'h00, 5'd1,  1'b1, 1'b0, 1'b0}, // empty table
            '{OP_ADD,        8'h00, 8'h05, 8'h5a, 5'd1,  1'b1, 1'b0, 1'b0}, // id zero
            '{OP_CANCEL,     8'h00, 8'h00, 8'h00, 5'd1,  1'b1, 1'b0, 1'b0},
            '{OP_CANCEL,     8'h07, 8'h00, 8'h00, 5'd1,  1'b1, 1'b0, 1'b0}, // not present
            '{OP_ADD,        8'h01, 8'h00, 8'hff, 5'd1,  1'b1, 1'b1, 1'b0},
            '{OP_ADD,        8'hff, 8'hff, 8'h00, 5'd1,  1'b1, 1'b1, 1'b0},
            '{OP_ADD,        8'h01, 8'h10, 8'haa, 5'd1,  1'b1, 1'b1, 1'b0}, // re-add
            '{OP_PERIODIC,   8'h00, 8'h00, 8'h00, 5'd3,  1'b0, 1'b0, 1'b0},
            '{OP_CANCEL,     8'hff, 8'h00, 8'h00, 5'd1,  1'b1, 1'b1, 1'b0},
            '{OP_CANCEL,     8'hff, 8'h00, 8'h00, 5'd1,  1'b1, 1'b0, 1'b0},
            '{OP_CANCEL_ALL, 8'h00, 8'h00, 8'h00, 5'd1,  1'b1, 1'b0, 1'b0},
            '{OP_ADD,        8'h20, 8'h00, 8'h3c, 5'd16, 1'b1, 1'b1, 1'b0}, // fill table
            '{OP_ADD,        8'h80, 8'h00, 8'h01, 5'd1,  1'b1, 1'b0, 1'b0}, // table full
            '{OP_ADD,        8'h25, 8'h01, 8'hc3, 5'd1,  1'b1, 1'b1, 1'b0}, // same id, full
            '{OP_PERIODIC,   8'h00, 8'h00, 8'h00, 5'd2,  1'b0, 1'b0, 1'b0}, // mass dispatch
            '{OP_CANCEL_ALL, 8'h00, 8'h00, 8'h00, 5'd1,  1'b1, 1'b0, 1'b0},
            '{OP_ADD,        8'h31, 8'h80, 8'h11, 5'd1,  1'b1, 1'b1, 1'b0}, // delay classes
            '{OP_ADD,        8'h34, 8'h10, 8'h44, 5'd4,  1'b1, 1'b1, 1'b0},
            '{OP_ADD,        8'h39, 8'h40, 8'h99, 5'd1,  1'b1, 1'b1, 1'b0},
            '{OP_PERIODIC,   8'h00, 8'h00, 8'h00, 5'd6,  1'b0, 1'b0, 1'b0}
        };
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[n]) begin
            row = dir_rows[n];
            for (int k = 0; k < row.cnt; k++) begin
                offer_beat(row.op, row.id + k[7:0], row.dly + k[7:0], row.par,
                           row.typed, row.t_ok, row.t_pend);
            end
        end

        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == 60) begin
                hold_req = 1'b1;
            end
            if (n == 140) begin
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (owed_beats.size() != 0);
            end
            r = $urandom_range(0, 99);
            if (r < 40)      op = OP_ADD;
            else if (r < 55) op = OP_CANCEL;
            else if (r < 58) op = OP_CANCEL_ALL;
            else             op = OP_PERIODIC;
            // small id pool so cancels hit and the table fills now and then
            r = $urandom_range(0, 19);
            if (r == 0)      id = 8'd0;
            else if (r == 1) id = 8'($urandom_range(0, 255));
            else             id = 8'($urandom_range(1, 24));
            r = $urandom_range(0, 9);
            if (r < 6)       dly = 8'($urandom_range(0, 6));
            else if (r < 8)  dly = 8'($urandom_range(0, 8'h1f));
            else             dly = 8'($urandom_range(0, 255));
            offer_beat(op, id, dly, 8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
        end
        s_tvalid <= 1'b0;

        while (owed_beats.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (n_errors == 0 && owed_beats.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### sim.f
hdl/tts_pkg.sv
hdl/tts_ctrl.sv
hdl/tts_datapath.sv
hdl/timed_task_slot_scheduler.sv
tb/sv/tb_timed_task_slot_scheduler.sv
